FILE: rtl/iee_pkg.sv
// Package for the infix expression evaluator: codes, state enum, command/status structs.
// No dependencies.
`default_nettype none
package iee_pkg;
  localparam int StackDepthDef = 16;
  localparam int ValueWidthDef = 32;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DIV0     = 3'd1,
    ST_MISSING  = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_BADCHAR  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_RD, S_RD2, S_EXEC, S_DIV, S_WB, S_PUSHOP, S_FIN, S_FINRD, S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic push_digit;  // push digit onto operand stack
    logic push_op;     // push current operator
    logic pop_op;      // pop operator stack (latch top op)
    logic rd_lhs;      // read operand at count-2
    logic rd_rhs;      // read operand at count-1
    logic exec;        // compute add/sub/mul or start divide
    logic wb;          // write result, count -= 1
    logic rd_bottom;   // read entry 0
    logic load_out;    // load output register
    logic clear;       // clear counts and error
    logic set_err;
    status_t err;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic opnd_full;
    logic opr_full;
    logic opr_empty;
    logic top_ge;      // stacked top precedence >= current
    logic opnd_lt2;
    logic opnd_one;
    logic rhs_zero;
    logic is_div;
    logic div_done;
  } stat_t;
endpackage
`default_nettype wire

FILE: rtl/infix_expression_evaluator.sv
// Top level of the infix expression evaluator: controller plus datapath.
// Depends on iee_pkg, iee_ctrl, iee_datapath.
// A digit is pushed; an operator first applies each stacked operator of no lower precedence.
// Last item drains pending operators, loads the result; out_tvalid rises as in_tready returns.
// Throughput: one item at a time; a result still waiting for out_tready holds the final item.
// Reset (rst_n low, synchronous) empties both stacks, clears the error and output valid.
`default_nettype none
module infix_expression_evaluator import iee_pkg::*; #(
  parameter int STACK_DEPTH = StackDepthDef,
  parameter int VALUE_WIDTH = ValueWidthDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] symbol
  input  wire logic        in_tlast,   // final_symbol
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // [31:0] value, [34:32] status, zero fill
);
  cmd_t cmd;
  stat_t stat;
  status_t err_code;
  logic [7:0] sym;
  logic [31:0] val;
  logic [2:0] st;

  iee_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_sym(in_tdata), .in_last(in_tlast), .sym(sym), .out_tvalid(out_tvalid),
    .out_tready(out_tready), .cmd(cmd), .stat(stat), .err_code(err_code)
  );

  iee_datapath #(.STACK_DEPTH(STACK_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .sym(sym), .cmd(cmd), .stat(stat),
    .err_code(err_code), .out_value(val), .out_status(st)
  );

  assign out_tdata = {5'd0, st, val};
endmodule
`default_nettype wire

FILE: rtl/iee_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on iee_pkg.
`default_nettype none
module iee_divider import iee_pkg::*; #(
  parameter int VALUE_WIDTH = ValueWidthDef
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [VALUE_WIDTH-1:0] dividend,
  input  wire logic [VALUE_WIDTH-1:0] divisor,
  output logic                        done,
  output logic [VALUE_WIDTH-1:0]      quotient
);
  localparam int CW = $clog2(VALUE_WIDTH + 1);
  logic [VALUE_WIDTH-1:0] q_r, q_nxt, d_r, d_nxt;
  logic [VALUE_WIDTH:0]   rem_r, rem_nxt, trial;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, neg_r, neg_nxt, done_r, done_nxt;

  always_comb begin
    q_nxt = q_r; d_nxt = d_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; neg_nxt = neg_r; done_nxt = 1'b0;
    trial = {rem_r[VALUE_WIDTH-1:0], q_r[VALUE_WIDTH-1]} - {1'b0, d_r};
    if (start) begin
      q_nxt = dividend[VALUE_WIDTH-1] ? -dividend : dividend;
      d_nxt = divisor[VALUE_WIDTH-1] ? -divisor : divisor;
      neg_nxt = dividend[VALUE_WIDTH-1] ^ divisor[VALUE_WIDTH-1];
      rem_nxt = '0;
      cnt_nxt = CW'(VALUE_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[VALUE_WIDTH]) begin
        rem_nxt = trial;
        q_nxt = {q_r[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[VALUE_WIDTH-1:0], q_r[VALUE_WIDTH-1]};
        q_nxt = {q_r[VALUE_WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt; d_r <= d_nxt; rem_r <= rem_nxt; neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quotient = neg_r ? -q_r : q_r;
endmodule
`default_nettype wire

FILE: rtl/iee_datapath.sv
// Datapath: operand and operator stacks, ALU with multiplier and divider, output register.
// Depends on iee_pkg and iee_divider.
`default_nettype none
module iee_datapath import iee_pkg::*; #(
  parameter int STACK_DEPTH = StackDepthDef,
  parameter int VALUE_WIDTH = ValueWidthDef
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] sym,
  input  wire cmd_t       cmd,
  output stat_t           stat,
  output status_t         err_code,
  output logic [31:0]     out_value,
  output logic [2:0]      out_status
);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [VALUE_WIDTH-1:0] opnd_mem [STACK_DEPTH];
  logic [1:0]             opr_mem  [STACK_DEPTH];
  logic [CW-1:0] ocnt_r, ocnt_nxt, pcnt_r, pcnt_nxt;
  status_t err_r, err_nxt;
  logic [VALUE_WIDTH-1:0] rhs_r, rd_r, res_r;
  logic [1:0] op_r, top_op_r, cur_code;
  logic [31:0] oval_r;
  logic [2:0]  ostat_r;
  logic [VALUE_WIDTH-1:0] quo;
  logic div_done;
  logic [CW-1:0] rd_idx;

  always_comb begin
    case (sym)
      ChPlus:  cur_code = OP_ADD;
      ChMinus: cur_code = OP_SUB;
      ChStar:  cur_code = OP_MUL;
      default: cur_code = OP_DIV;
    endcase
  end

  always_comb begin
    ocnt_nxt = ocnt_r; pcnt_nxt = pcnt_r; err_nxt = err_r;
    if (cmd.push_digit) ocnt_nxt = ocnt_r + 1'b1;
    if (cmd.push_op) pcnt_nxt = pcnt_r + 1'b1;
    if (cmd.pop_op) pcnt_nxt = pcnt_r - 1'b1;
    if (cmd.wb) ocnt_nxt = ocnt_r - 1'b1;
    if (cmd.set_err && err_r == ST_OK) err_nxt = cmd.err;
    if (cmd.clear) begin
      ocnt_nxt = '0; pcnt_nxt = '0; err_nxt = ST_OK;
    end
  end

  // the result replaces the left operand, one below the top
  always_comb begin
    rd_idx = ocnt_r - 1'b1;
    if (cmd.rd_lhs || cmd.wb) rd_idx = ocnt_r - CW'(2);
    if (cmd.rd_bottom) rd_idx = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= '0;
      pcnt_r <= '0;
      err_r  <= ST_OK;
    end else begin
      ocnt_r <= ocnt_nxt;
      pcnt_r <= pcnt_nxt;
      err_r  <= err_nxt;
    end
  end

  // stack memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (cmd.push_digit)
      opnd_mem[ocnt_r[AW-1:0]] <= VALUE_WIDTH'(sym - ChZero);
    else if (cmd.wb)
      opnd_mem[rd_idx[AW-1:0]] <= res_r;
    rd_r <= opnd_mem[rd_idx[AW-1:0]];
    if (cmd.push_op) opr_mem[pcnt_r[AW-1:0]] <= cur_code;
    // a fresh push is the new top; bypass the memory read
    top_op_r <= cmd.push_op ? cur_code : opr_mem[AW'(pcnt_r - 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (cmd.pop_op) op_r <= top_op_r;
    if (cmd.rd_lhs) rhs_r <= rd_r;   // rhs read issued the cycle before
    if (cmd.exec) begin
      case (op_r)
        OP_ADD:  res_r <= rd_r + rhs_r;
        OP_SUB:  res_r <= rd_r - rhs_r;
        OP_MUL:  res_r <= rd_r * rhs_r;
        default: res_r <= res_r;
      endcase
    end else if (div_done) begin
      res_r <= quo;
    end
    if (cmd.load_out) begin
      ostat_r <= err_r;
      oval_r  <= (err_r == ST_OK) ? 32'($signed(rd_r)) : 32'd0;
    end
  end

  iee_divider #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
    .clk(clk), .rst_n(rst_n),
    .start(cmd.exec && op_r == OP_DIV),
    .dividend(rd_r), .divisor(rhs_r),
    .done(div_done), .quotient(quo)
  );

  assign stat.opnd_full = (ocnt_r == CW'(STACK_DEPTH));
  assign stat.opr_full  = (pcnt_r == CW'(STACK_DEPTH));
  assign stat.opr_empty = (pcnt_r == '0);
  assign stat.top_ge    = (top_op_r[1] >= cur_code[1]);
  assign stat.opnd_lt2  = (ocnt_r < CW'(2));
  assign stat.opnd_one  = (ocnt_r == CW'(1));
  assign stat.rhs_zero  = (rhs_r == '0);
  assign stat.is_div    = (op_r == OP_DIV);
  assign stat.div_done  = div_done;
  assign err_code   = err_r;
  assign out_value  = oval_r;
  assign out_status = ostat_r;
endmodule
`default_nettype wire

FILE: rtl/iee_ctrl.sv
// Controller state machine: sequences pushes, operator application and the result.
// Depends on iee_pkg.
`default_nettype none
module iee_ctrl import iee_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_sym,
  input  wire logic       in_last,
  output logic [7:0]      sym,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output cmd_t            cmd,
  input  wire stat_t      stat,
  input  wire status_t    err_code
);
  state_t state_r, state_nxt;
  logic [7:0] sym_r;
  logic last_r, is_digit, is_op, ov_r, ov_nxt;

  assign sym = sym_r;
  assign is_digit = (sym_r >= ChZero) && (sym_r <= ChNine);
  assign is_op = (sym_r == ChPlus) || (sym_r == ChMinus) ||
                 (sym_r == ChStar) || (sym_r == ChSlash);

  always_comb begin
    state_nxt = state_r;
    ov_nxt = ov_r && !out_tready;
    cmd = '0;
    cmd.err = ST_OK;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (err_code != ST_OK) begin
          state_nxt = last_r ? S_FIN : S_IDLE;
        end else if (is_digit) begin
          if (stat.opnd_full) begin
            cmd.set_err = 1'b1; cmd.err = ST_OVERFLOW;
          end else begin
            cmd.push_digit = 1'b1;
          end
          state_nxt = last_r ? S_FIN : S_IDLE;
        end else if (!is_op) begin
          cmd.set_err = 1'b1; cmd.err = ST_BADCHAR;
          state_nxt = last_r ? S_FIN : S_IDLE;
        end else if (!stat.opr_empty && stat.top_ge) begin
          cmd.pop_op = 1'b1;
          state_nxt = S_RD;
        end else begin
          state_nxt = S_PUSHOP;
        end
      end
      S_RD: begin
        if (stat.opnd_lt2) begin
          cmd.set_err = 1'b1; cmd.err = ST_MISSING;
          state_nxt = last_r ? S_FIN : S_IDLE;
        end else begin
          cmd.rd_rhs = 1'b1;
          state_nxt = S_RD2;
        end
      end
      S_RD2: begin
        cmd.rd_lhs = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (stat.is_div && stat.rhs_zero) begin
          cmd.set_err = 1'b1; cmd.err = ST_DIV0;
          state_nxt = last_r ? S_FIN : S_IDLE;
        end else begin
          cmd.exec = 1'b1;
          state_nxt = stat.is_div ? S_DIV : S_WB;
        end
      end
      S_DIV: if (stat.div_done) state_nxt = S_WB;
      S_WB: begin
        cmd.wb = 1'b1;
        // an incoming operator rechecks the stack top; the drain returns to S_FIN
        state_nxt = is_op ? S_CHECK : S_FIN;
      end
      S_PUSHOP: begin
        if (stat.opr_full) begin
          cmd.set_err = 1'b1; cmd.err = ST_OVERFLOW;
        end else begin
          cmd.push_op = 1'b1;
        end
        state_nxt = last_r ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        // drain pending operators; sym is forced non-operator
        if (err_code == ST_OK && !stat.opr_empty) begin
          cmd.pop_op = 1'b1;
          state_nxt = S_RD;
        end else begin
          if (err_code == ST_OK && !stat.opnd_one) begin
            cmd.set_err = 1'b1; cmd.err = ST_MISSING;
          end
          cmd.rd_bottom = 1'b1;
          state_nxt = S_FINRD;
        end
      end
      S_FINRD: begin
        if (!ov_r) begin
          cmd.load_out = 1'b1;
          cmd.clear = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (in_tready && in_tvalid) last_r <= in_last;
      else if (state_nxt == S_FIN && state_r != S_FIN && state_r != S_RD) last_r <= 1'b1;
    end
    if (in_tready && in_tvalid) sym_r <= in_sym;
    else if (state_r == S_FIN && state_nxt == S_RD) sym_r <= 8'd0;
  end

  assign out_tvalid = ov_r;

  a_wb_only_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb |-> $past(state_r == S_EXEC || state_r == S_DIV)) else $error("wb out of order");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE) else $error("ready while busy");
  a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !ov_r) else $error("output overwritten");
endmodule
`default_nettype wire
